// ----- rtl/lc4_pkg.sv -----
package lc4_pkg;

	localparam int unsigned MemWords = 65536;
	localparam int unsigned MemAw = (MemWords > 1) ? $clog2(MemWords) : 1;

	localparam logic [15:0] PcReset = 16'h8200;
	localparam logic [2:0] NzpReset = 3'b010;
	localparam logic [15:0] TrapBase = 16'h8000;

	localparam logic [2:0] NzpNeg = 3'b100;
	localparam logic [2:0] NzpZero = 3'b010;
	localparam logic [2:0] NzpPos = 3'b001;

	localparam logic [3:0] OpBr = 4'd0;
	localparam logic [3:0] OpArith = 4'd1;
	localparam logic [3:0] OpCmp = 4'd2;
	localparam logic [3:0] OpJsr = 4'd4;
	localparam logic [3:0] OpLogic = 4'd5;
	localparam logic [3:0] OpLdr = 4'd6;
	localparam logic [3:0] OpStr = 4'd7;
	localparam logic [3:0] OpRti = 4'd8;
	localparam logic [3:0] OpConst = 4'd9;
	localparam logic [3:0] OpShift = 4'd10;
	localparam logic [3:0] OpJmp = 4'd12;
	localparam logic [3:0] OpHiconst = 4'd13;
	localparam logic [3:0] OpTrap = 4'd15;

	localparam logic [1:0] AluAdd = 2'd0;
	localparam logic [1:0] AluMul = 2'd1;
	localparam logic [1:0] AluSub = 2'd2;
	localparam logic [1:0] AluDiv = 2'd3;
	localparam logic [1:0] LogAnd = 2'd0;
	localparam logic [1:0] LogNot = 2'd1;
	localparam logic [1:0] LogOr = 2'd2;
	localparam logic [1:0] LogXor = 2'd3;
	localparam logic [1:0] CmpSigned = 2'd0;
	localparam logic [1:0] CmpUnsigned = 2'd1;
	localparam logic [1:0] CmpSignedImm = 2'd2;
	localparam logic [1:0] CmpUnsignedImm = 2'd3;
	localparam logic [1:0] ShSll = 2'd0;
	localparam logic [1:0] ShSra = 2'd1;
	localparam logic [1:0] ShSrl = 2'd2;
	localparam logic [1:0] ShMod = 2'd3;

	typedef struct packed {
		logic        action;
		logic [15:0] address;
		logic [15:0] data;
	} lc4_in_t;

	typedef struct packed {
		logic [15:0] pc;
		logic [2:0]  nzp;
		logic        privileged;
		logic        halted;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
	} lc4_out_t;

	function automatic logic [2:0] nzp_of(input logic [15:0] v);
		if (v[15]) return NzpNeg;
		if (v == 16'd0) return NzpZero;
		return NzpPos;
	endfunction

endpackage

// ----- rtl/lc4_if.sv -----
interface lc4_in_if;
	logic             valid;
	logic             ready;
	lc4_pkg::lc4_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface lc4_out_if;
	logic              valid;
	logic              ready;
	lc4_pkg::lc4_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/lc4_instruction_execute.sv -----
// LC4 core, one instruction per step beat.
// Channels: in_ch (sink) carries {action, address, data}; out_ch (source)
// carries one result beat per input beat: pc, nzp, privileged, halted and
// the register write made by that step.
// A write beat (action 0) stores data at address and returns the state.
// A step beat (action 1) fetches the word at PC, decodes and executes it.
// From accept to result valid: a write beat goes straight to the result
// load; a step beat runs fetch read, execute with STR write / LDR read
// issue, write-back and result load; LDR also waits for the load data.
// DIV and MOD run a bit-serial divider between execute and write-back.
// One beat is in flight at a time; a new beat is taken only once the core
// is back in idle after the result is loaded.
// Reset: registers clear, PC 0x8200, NZP zero, privilege set. Memory is
// swept to zero first, one word per cycle, while in_ch is held not ready.
// Receiver stall: the result holds in the output register while the next
// beat runs; that beat then holds in its last stage until the register frees.
module lc4_instruction_execute (
	input logic clk,
	input logic arst_n,
	lc4_in_if.sink in_ch,
	lc4_out_if.source out_ch
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b00000001,
		ST_IDLE  = 8'b00000010,
		ST_FETCH = 8'b00000100,
		ST_EXEC  = 8'b00001000,
		ST_DIV   = 8'b00010000,
		ST_LOAD  = 8'b00100000,
		ST_WB    = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;

	state_t state_q;

	logic [15:0] mem [lc4_pkg::MemWords];
	logic [15:0] rdata_q;
	logic        mem_we;
	logic [15:0] mem_wa, mem_wd, mem_ra;

	logic [15:0] regs_q [8];
	logic [15:0] pc_q;
	logic [2:0]  nzp_q;
	logic        priv_q;
	logic [lc4_pkg::MemAw:0] clr_q;

	logic        wr_q;
	logic [2:0]  widx_q;
	logic [15:0] wval_q;
	logic [15:0] next_q;
	logic        halt_q;
	logic        valid_q;
	lc4_pkg::lc4_out_t res_q;

	// divider
	logic [15:0] quo_q, rem_q, dvs_q;
	logic [4:0]  dcnt_q;
	logic        dmod_q;
	wire [16:0]  dsh = {rem_q, quo_q[15]};
	wire [16:0]  dsub = dsh - {1'b0, dvs_q};

	wire accept = in_ch.valid && in_ch.ready;
	// load the result register once the previous result is gone or leaving
	wire done_go = (state_q == ST_DONE) && (!valid_q || out_ch.ready);
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = valid_q;
	assign out_ch.payload = res_q;

	function automatic logic in_range(input logic [15:0] a);
		return 32'(a) < lc4_pkg::MemWords;
	endfunction

	// decode fields; the fetched word sits in rdata_q during ST_EXEC
	wire [15:0] ir = rdata_q;
	wire [3:0]  op = ir[15:12];
	wire [2:0]  rd = ir[11:9];
	wire [15:0] ra = regs_q[ir[11:9]];
	wire [15:0] rs = regs_q[ir[8:6]];
	wire [15:0] rt = regs_q[ir[2:0]];
	wire [15:0] pc1 = pc_q + 16'd1;
	wire [15:0] imm5 = {{11{ir[4]}}, ir[4:0]};
	wire [15:0] imm6 = {{10{ir[5]}}, ir[5:0]};
	wire [15:0] imm7 = {{9{ir[6]}}, ir[6:0]};
	wire [15:0] imm9 = {{7{ir[8]}}, ir[8:0]};
	wire [15:0] imm11 = {{5{ir[10]}}, ir[10:0]};
	wire [15:0] ea = rs + imm6;
	wire [3:0]  amt = ir[3:0];
	wire [31:0] prod = rs * rt;
	wire [15:0] sra_v = 16'($signed(rs) >>> amt);

	logic        e_wr, e_div, e_load, e_cc;
	logic [2:0]  e_widx, e_ccv;
	logic [15:0] e_wval, e_next;
	logic        e_priv_set, e_priv_clr;

	always_comb begin
		e_wr = 1'b0; e_div = 1'b0; e_load = 1'b0; e_cc = 1'b0; e_ccv = nzp_q;
		e_widx = rd; e_wval = 16'd0; e_next = pc1;
		e_priv_set = 1'b0; e_priv_clr = 1'b0;
		case (op)
			lc4_pkg::OpBr: begin
				if ((ir[11:9] & nzp_q) != 3'd0) e_next = pc1 + imm9;
			end
			lc4_pkg::OpArith: begin
				e_wr = 1'b1;
				if (ir[5]) e_wval = rs + imm5;
				else begin
					case (ir[4:3])
						lc4_pkg::AluAdd: e_wval = rs + rt;
						lc4_pkg::AluMul: e_wval = prod[15:0];
						lc4_pkg::AluSub: e_wval = rs - rt;
						default: e_div = 1'b1;
					endcase
				end
			end
			lc4_pkg::OpCmp: begin
				e_cc = 1'b1;
				case (ir[8:7])
					lc4_pkg::CmpSigned: e_ccv = ($signed(ra) < $signed(rt)) ?
						lc4_pkg::NzpNeg : (ra == rt) ? lc4_pkg::NzpZero : lc4_pkg::NzpPos;
					lc4_pkg::CmpUnsigned: e_ccv = (ra < rt) ? lc4_pkg::NzpNeg :
						(ra == rt) ? lc4_pkg::NzpZero : lc4_pkg::NzpPos;
					lc4_pkg::CmpSignedImm: e_ccv = ($signed(ra) < $signed(imm7)) ?
						lc4_pkg::NzpNeg : (ra == imm7) ? lc4_pkg::NzpZero : lc4_pkg::NzpPos;
					default: e_ccv = (ra < {9'd0, ir[6:0]}) ? lc4_pkg::NzpNeg :
						(ra == {9'd0, ir[6:0]}) ? lc4_pkg::NzpZero : lc4_pkg::NzpPos;
				endcase
			end
			lc4_pkg::OpJsr: begin
				e_wr = 1'b1; e_widx = 3'd7; e_wval = pc1;
				e_next = ir[11] ? {pc_q[15], ir[10:0], 4'd0} : rs;
			end
			lc4_pkg::OpLogic: begin
				e_wr = 1'b1;
				if (ir[5]) e_wval = rs & imm5;
				else begin
					case (ir[4:3])
						lc4_pkg::LogAnd: e_wval = rs & rt;
						lc4_pkg::LogNot: e_wval = ~rs;
						lc4_pkg::LogOr: e_wval = rs | rt;
						default: e_wval = rs ^ rt;
					endcase
				end
			end
			lc4_pkg::OpLdr: begin
				e_wr = 1'b1; e_load = 1'b1;
			end
			lc4_pkg::OpRti: begin
				e_next = regs_q[7]; e_priv_clr = 1'b1;
			end
			lc4_pkg::OpConst: begin
				e_wr = 1'b1; e_wval = imm9;
			end
			lc4_pkg::OpShift: begin
				e_wr = 1'b1;
				case (ir[5:4])
					lc4_pkg::ShSll: e_wval = rs << amt;
					lc4_pkg::ShSra: e_wval = sra_v;
					lc4_pkg::ShSrl: e_wval = rs >> amt;
					default: e_div = 1'b1;
				endcase
			end
			lc4_pkg::OpJmp: begin
				e_next = ir[11] ? pc1 + imm11 : rs;
			end
			lc4_pkg::OpHiconst: begin
				e_wr = 1'b1; e_wval = {ir[7:0], ra[7:0]};
			end
			lc4_pkg::OpTrap: begin
				e_wr = 1'b1; e_widx = 3'd7; e_wval = pc1;
				e_next = lc4_pkg::TrapBase | {8'd0, ir[7:0]};
				e_priv_set = 1'b1;
			end
			default: ;
		endcase
	end

	// memory port selection
	always_comb begin
		mem_we = 1'b0; mem_wa = 16'd0; mem_wd = 16'd0; mem_ra = pc_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1; mem_wa = 16'(clr_q);
			end
			ST_IDLE: begin
				mem_we = accept && !in_ch.payload.action && in_range(in_ch.payload.address);
				mem_wa = in_ch.payload.address; mem_wd = in_ch.payload.data;
			end
			ST_EXEC: begin
				mem_ra = ea;
				mem_we = (op == lc4_pkg::OpStr) && in_range(ea);
				mem_wa = ea; mem_wd = ra;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa[lc4_pkg::MemAw-1:0]] <= mem_wd;
		rdata_q <= in_range(mem_ra) ? mem[mem_ra[lc4_pkg::MemAw-1:0]] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			pc_q <= lc4_pkg::PcReset;
			nzp_q <= lc4_pkg::NzpReset;
			priv_q <= 1'b1;
			valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) regs_q[i] <= 16'd0;
			wr_q <= 1'b0; halt_q <= 1'b0;
			dcnt_q <= 5'd0;
		end else begin
			if (done_go) valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == lc4_pkg::MemWords - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						wr_q <= 1'b0; halt_q <= 1'b0;
						state_q <= in_ch.payload.action ? ST_FETCH : ST_DONE;
					end
				end
				ST_FETCH: begin
					// rdata_q holds the instruction next cycle
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (ir == 16'd0) begin
						halt_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						wr_q <= e_wr; widx_q <= e_widx; wval_q <= e_wval;
						next_q <= e_next;
						if (e_cc) nzp_q <= e_ccv;
						if (e_priv_set) priv_q <= 1'b1;
						if (e_priv_clr) priv_q <= 1'b0;
						if (e_div) begin
							quo_q <= rs; rem_q <= 16'd0; dvs_q <= rt;
							dmod_q <= (op == lc4_pkg::OpShift);
							dcnt_q <= 5'd16;
							state_q <= ST_DIV;
						end else if (e_load) state_q <= ST_LOAD;
						else state_q <= ST_WB;
					end
				end
				ST_DIV: begin
					if (dcnt_q != 5'd0) begin
						// restoring divide, one quotient bit per cycle
						if (dsh >= {1'b0, dvs_q}) begin
							rem_q <= dsub[15:0];
							quo_q <= {quo_q[14:0], 1'b1};
						end else begin
							rem_q <= dsh[15:0];
							quo_q <= {quo_q[14:0], 1'b0};
						end
						dcnt_q <= dcnt_q - 5'd1;
					end else begin
						wval_q <= (dvs_q == 16'd0) ? 16'd0 : (dmod_q ? rem_q : quo_q);
						state_q <= ST_WB;
					end
				end
				ST_LOAD: begin
					wval_q <= rdata_q;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wr_q) begin
						regs_q[widx_q] <= wval_q;
						nzp_q <= lc4_pkg::nzp_of(wval_q);
					end
					pc_q <= next_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			res_q.pc <= pc_q;
			res_q.nzp <= nzp_q;
			res_q.privileged <= priv_q;
			res_q.halted <= halt_q;
			res_q.reg_written <= wr_q;
			res_q.reg_index <= wr_q ? widx_q : 3'd0;
			res_q.reg_value <= wr_q ? wval_q : 16'd0;
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> (state_q == ST_IDLE))
		else $error("beat accepted while busy");
	a_valid_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_ch.valid)
		else $error("result not raised after completion");
	a_halt_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.payload.halted) |-> !out_ch.payload.reg_written)
		else $error("halted step wrote a register");
`endif

endmodule

// ----- tb/lc4_exec_monitor.sv -----
`timescale 1ns / 1ps

module lc4_exec_monitor (
	input logic clk,
	input logic arst_n,
	lc4_in_if in_ch,
	lc4_out_if out_ch,
	output int fails
);

	logic [15:0] mem [lc4_pkg::MemWords];
	logic [15:0] regs [8];
	logic [15:0] cur_pc;
	logic [2:0]  cur_nzp;
	logic        cur_priv;
	lc4_pkg::lc4_out_t pending_results [$];
	int          mismatches;

	function automatic logic [2:0] order_code(input logic signed [16:0] x,
		input logic signed [16:0] y);
		if (x < y) return lc4_pkg::NzpNeg;
		if (x == y) return lc4_pkg::NzpZero;
		return lc4_pkg::NzpPos;
	endfunction

	task automatic execute_beat(input lc4_pkg::lc4_in_t b, output lc4_pkg::lc4_out_t r);
		logic [15:0] ir, a, rs, rt, nxt, val, sx5, sx6, sx7, sx9, sx11, ea;
		logic [3:0]  amt;
		logic        wr;
		logic [2:0]  idx;
		r = '0;
		wr = 1'b0;
		idx = 3'd0;
		val = 16'd0;
		if (!b.action) begin
			mem[b.address] = b.data;
		end else begin
			ir = mem[cur_pc];
			if (ir == 16'd0) begin
				r.halted = 1'b1;
			end else begin
				a = regs[ir[11:9]];
				rs = regs[ir[8:6]];
				rt = regs[ir[2:0]];
				amt = ir[3:0];
				sx5 = {{11{ir[4]}}, ir[4:0]};
				sx6 = {{10{ir[5]}}, ir[5:0]};
				sx7 = {{9{ir[6]}}, ir[6:0]};
				sx9 = {{7{ir[8]}}, ir[8:0]};
				sx11 = {{5{ir[10]}}, ir[10:0]};
				ea = rs + sx6;
				nxt = cur_pc + 16'd1;
				case (ir[15:12])
					lc4_pkg::OpBr: begin
						if ((ir[11:9] & cur_nzp) != 3'd0) nxt = cur_pc + 16'd1 + sx9;
					end
					lc4_pkg::OpArith: begin
						wr = 1'b1; idx = ir[11:9];
						if (ir[5]) val = rs + sx5;
						else case (ir[4:3])
							lc4_pkg::AluAdd: val = rs + rt;
							lc4_pkg::AluMul: val = rs * rt;
							lc4_pkg::AluSub: val = rs - rt;
							default: val = (rt != 0) ? rs / rt : 16'd0;
						endcase
					end
					lc4_pkg::OpCmp: begin
						case (ir[8:7])
							lc4_pkg::CmpSigned:
								cur_nzp = order_code({a[15], a}, {rt[15], rt});
							lc4_pkg::CmpUnsigned:
								cur_nzp = order_code({1'b0, a}, {1'b0, rt});
							lc4_pkg::CmpSignedImm:
								cur_nzp = order_code({a[15], a}, {sx7[15], sx7});
							default:
								cur_nzp = order_code({1'b0, a}, {10'd0, ir[6:0]});
						endcase
					end
					lc4_pkg::OpJsr: begin
						wr = 1'b1; idx = 3'd7; val = cur_pc + 16'd1;
						nxt = ir[11] ? {cur_pc[15], ir[10:0], 4'd0} : rs;
					end
					lc4_pkg::OpLogic: begin
						wr = 1'b1; idx = ir[11:9];
						if (ir[5]) val = rs & sx5;
						else case (ir[4:3])
							lc4_pkg::LogAnd: val = rs & rt;
							lc4_pkg::LogNot: val = ~rs;
							lc4_pkg::LogOr: val = rs | rt;
							default: val = rs ^ rt;
						endcase
					end
					lc4_pkg::OpLdr: begin
						wr = 1'b1; idx = ir[11:9]; val = mem[ea];
					end
					lc4_pkg::OpStr: mem[ea] = a;
					lc4_pkg::OpRti: begin
						nxt = regs[7];
						cur_priv = 1'b0;
					end
					lc4_pkg::OpConst: begin
						wr = 1'b1; idx = ir[11:9]; val = sx9;
					end
					lc4_pkg::OpShift: begin
						wr = 1'b1; idx = ir[11:9];
						case (ir[5:4])
							lc4_pkg::ShSll: val = rs << amt;
							lc4_pkg::ShSra: val = $signed(rs) >>> amt;
							lc4_pkg::ShSrl: val = rs >> amt;
							default: val = (rt != 0) ? rs % rt : 16'd0;
						endcase
					end
					lc4_pkg::OpJmp: nxt = ir[11] ? cur_pc + 16'd1 + sx11 : rs;
					lc4_pkg::OpHiconst: begin
						wr = 1'b1; idx = ir[11:9]; val = {ir[7:0], a[7:0]};
					end
					lc4_pkg::OpTrap: begin
						wr = 1'b1; idx = 3'd7; val = cur_pc + 16'd1;
						nxt = lc4_pkg::TrapBase | {8'd0, ir[7:0]};
						cur_priv = 1'b1;
					end
					default: ;
				endcase
				if (wr) begin
					regs[idx] = val;
					cur_nzp = order_code({val[15], val}, 17'sd0);
				end
				cur_pc = nxt;
			end
		end
		r.pc = cur_pc;
		r.nzp = cur_nzp;
		r.privileged = cur_priv;
		r.reg_written = wr;
		r.reg_index = idx;
		r.reg_value = val;
	endtask

	task automatic report(input string what, input logic [15:0] exp_v, input logic [15:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %h got %h", $time, what, exp_v, act_v);
	endtask

	initial begin
		foreach (mem[i]) mem[i] = 16'd0;
		foreach (regs[i]) regs[i] = 16'd0;
		cur_pc = lc4_pkg::PcReset;
		cur_nzp = lc4_pkg::NzpReset;
		cur_priv = 1'b1;
		mismatches = 0;
	end

	always @(posedge clk) begin
		lc4_pkg::lc4_out_t exp_r, act_r;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			execute_beat(in_ch.payload, exp_r);
			pending_results.push_back(exp_r);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			act_r = out_ch.payload;
			if (pending_results.size() == 0) begin
				report("unexpected result pc", 16'd0, act_r.pc);
			end else begin
				exp_r = pending_results.pop_front();
				if (act_r.pc !== exp_r.pc) report("pc", exp_r.pc, act_r.pc);
				if (act_r.nzp !== exp_r.nzp)
					report("nzp", 16'(exp_r.nzp), 16'(act_r.nzp));
				if (act_r.privileged !== exp_r.privileged)
					report("privileged", 16'(exp_r.privileged), 16'(act_r.privileged));
				if (act_r.halted !== exp_r.halted)
					report("halted", 16'(exp_r.halted), 16'(act_r.halted));
				if (act_r.reg_written !== exp_r.reg_written)
					report("reg_written", 16'(exp_r.reg_written), 16'(act_r.reg_written));
				if (act_r.reg_index !== exp_r.reg_index)
					report("reg_index", 16'(exp_r.reg_index), 16'(act_r.reg_index));
				if (act_r.reg_value !== exp_r.reg_value)
					report("reg_value", exp_r.reg_value, act_r.reg_value);
			end
		end
		fails <= mismatches + pending_results.size();
	end

endmodule

// ----- tb/tb_lc4_instruction_execute.sv -----
`timescale 1ns / 1ps

module tb_lc4_instruction_execute;

	// Opcodes the core leaves unused: they must act as a NOP.
	localparam logic [3:0] OpSpare3 = 4'd3, OpSpare11 = 4'd11, OpSpare14 = 4'd14;
	localparam logic ActWrite = 1'b0, ActStep = 1'b1;
	localparam int HoldCycles = 400;
	localparam int WatchdogLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fails;

	lc4_in_if in_ch ();
	lc4_out_if out_ch ();

	lc4_instruction_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	lc4_exec_monitor mon (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fails(fails)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	int          idle_pct = 0;    // chance the sender skips a cycle
	int          stall_pct = 0;   // chance the receiver stalls a cycle
	logic        hold_start;
	int          hold_left = 0;
	int          sent = 0;
	int          got = 0;
	int          quiet = 0;
	logic [15:0] last_pc = lc4_pkg::PcReset;

	// Receiver: random stalls, plus a long hold-off on request to back up the core.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_start) begin
			hold_left <= HoldCycles;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Track results so each new program word lands at the current PC.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			got <= got + 1;
			last_pc <= out_ch.payload.pc;
		end
	end

	// Watchdog: count cycles where neither channel moves a beat.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WatchdogLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one beat; hold it until taken. Valid stays high into the next beat
	// unless the sender idles, so there is one assignment per step.
	task automatic send(input logic act, input logic [15:0] addr, input logic [15:0] dat);
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{action: act, address: addr, data: dat};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	// If results are outstanding, drop valid and wait until every one has come back.
	task automatic drain();
		if (sent != got) begin
			in_ch.valid <= 1'b0;
			while (sent != got) @(posedge clk);
		end
	endtask

	// Place a word at the current PC, then execute it.
	task automatic run_word(input logic [15:0] instr);
		drain();
		send(ActWrite, last_pc, instr);
		send(ActStep, 16'($urandom), 16'($urandom));
	endtask

	function automatic logic [15:0] rand_instr();
		logic [3:0] op;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 3) return 16'd0;
		case ($urandom_range(15))
			0: op = lc4_pkg::OpBr;
			1: op = lc4_pkg::OpArith;
			2: op = lc4_pkg::OpCmp;
			3: op = lc4_pkg::OpJsr;
			4: op = lc4_pkg::OpLogic;
			5: op = lc4_pkg::OpLdr;
			6: op = lc4_pkg::OpStr;
			7: op = lc4_pkg::OpRti;
			8: op = lc4_pkg::OpConst;
			9: op = lc4_pkg::OpShift;
			10: op = lc4_pkg::OpJmp;
			11: op = lc4_pkg::OpHiconst;
			12: op = lc4_pkg::OpTrap;
			13: op = OpSpare3;
			14: op = OpSpare11;
			default: op = OpSpare14;
		endcase
		return {op, 12'($urandom)};
	endfunction

	task automatic random_phase(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(99) < 80) run_word(rand_instr());
			else if ($urandom_range(1)) send(ActWrite, 16'($urandom), 16'($urandom));
			else send(ActStep, 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		hold_start = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: memory is zero after reset, so the first step halts.
		send(ActStep, 16'h0000, 16'h0000);
		send(ActWrite, 16'hFFFF, 16'hFFFF);
		send(ActWrite, 16'h0000, 16'h0000);
		run_word({lc4_pkg::OpArith, 3'd1, 3'd0, 3'b011, 3'd0});        // divide by zero
		run_word({lc4_pkg::OpShift, 3'd2, 3'd0, 2'b11, 4'd0});         // modulo by zero
		run_word({lc4_pkg::OpConst, 3'd3, 9'h100});                    // most negative const
		run_word({lc4_pkg::OpHiconst, 3'd3, 1'b0, 8'hFF});
		run_word({lc4_pkg::OpArith, 3'd4, 3'd3, 1'b1, 5'h1F});         // add immediate -1
		run_word({lc4_pkg::OpCmp, 3'd3, 2'b11, 7'h7F});                // unsigned vs 127
		run_word({lc4_pkg::OpCmp, 3'd3, 2'b10, 7'h40});                // signed vs -64
		run_word({lc4_pkg::OpLogic, 3'd5, 3'd3, 3'b001, 3'd0});        // NOT
		run_word({lc4_pkg::OpShift, 3'd6, 3'd3, 2'b01, 4'hF});         // SRA by 15
		run_word({lc4_pkg::OpStr, 3'd3, 3'd0, 6'h3F});
		run_word({lc4_pkg::OpLdr, 3'd1, 3'd0, 6'h3F});
		run_word({lc4_pkg::OpBr, 3'b000, 9'h1FF});                     // no condition: NOP
		run_word({lc4_pkg::OpBr, 3'b111, 9'h0FF});
		run_word({OpSpare11, 12'hFFF});
		run_word({lc4_pkg::OpTrap, 4'd0, 8'hFF});
		run_word({lc4_pkg::OpRti, 12'hFFF});                           // back through R7
		run_word({lc4_pkg::OpJsr, 1'b1, 11'h7FF});
		run_word({lc4_pkg::OpJmp, 1'b0, 2'd0, 3'd7, 6'd0});            // JMPR R7
		run_word({lc4_pkg::OpJsr, 1'b0, 2'd0, 3'd7, 6'd0});            // JSRR R7
		run_word({lc4_pkg::OpJmp, 1'b1, 11'h400});

		// Random, through the idling phases.
		idle_pct = 0;  stall_pct = 0;  random_phase(140);
		idle_pct = 79; stall_pct = 0;  random_phase(70);
		idle_pct = 0;  stall_pct = 79; random_phase(70);
		idle_pct = 36; stall_pct = 36; random_phase(70);

		// Back up the core: long receiver hold-off while beats keep coming.
		drain();
		idle_pct = 0; stall_pct = 0;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		repeat (20) begin
			if ($urandom_range(1)) send(ActWrite, 16'($urandom), 16'($urandom));
			else send(ActStep, 16'($urandom), 16'($urandom));
		end
		random_phase(30);

		drain();
		in_ch.valid <= 1'b0;
		repeat (40) @(posedge clk);
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
